/* rtl/mtsc_pkg.sv */
// Package for the minimum-threshold strong connectivity block.
// Holds sizes, weight key helpers and the control state type; no dependencies.
package mtsc_pkg;
  localparam int MaxNodes   = 64;
  localparam int NodeBits   = $clog2(MaxNodes);
  localparam int CountBits  = NodeBits + 1;
  localparam int AddrBits   = 2 * NodeBits;
  localparam int StackBits  = NodeBits + CountBits;
  localparam int WeightBits = 32;
  localparam int CfgBits    = 7;

  typedef logic [WeightBits-1:0] key_t;
  typedef logic [NodeBits-1:0]   node_t;
  typedef logic [CountBits-1:0]  count_t;

  // key of weight zero; keys are offset binary so unsigned compares order them
  localparam key_t KeyZero = {1'b1, {(WeightBits-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PREP,
    ST_SEARCH,
    ST_ROOT,
    ST_FETCH,
    ST_SCAN,
    ST_EDGE,
    ST_STEP,
    ST_DECIDE,
    ST_OUT
  } state_t;

  function automatic key_t to_key(input logic [31:0] w);
    return w ^ KeyZero;
  endfunction
endpackage

/* rtl/mtsc_ram.sv */
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module mtsc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* rtl/min_threshold_strong_connectivity.sv */
// Minimum-threshold strong connectivity over a weight matrix. Uses mtsc_pkg, mtsc_ram.
// Load: one matrix item per cycle; in_stall stays low while loading unless a result waits.
// Search: after the last_entry item, up to 32 binary steps of two depth-first passes,
// each edge test passing through ST_SCAN and then ST_EDGE.
// Input stalls from the last_entry item until its result is taken. Reset (rst_n low,
// synchronous) sets node count 64, resets bounds, clears counters and visited bits; RAMs keep data.
module min_threshold_strong_connectivity (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_weight,
  input  logic                          in_last_entry,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_threshold,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mtsc_pkg::CfgBits-1:0]  cfg_node_count
);
  import mtsc_pkg::*;

  state_t state_r, state_nxt;
  logic [CfgBits-1:0] node_count_r;
  count_t n_use;
  node_t  n_max;
  node_t  row_r, col_r;
  logic   load_done_r;
  logic   loading_r;
  key_t   lo_r, hi_r, mid_r;
  logic [MaxNodes-1:0] vis_r;
  logic   pass_r;
  count_t done_r, idx_r, sp_r, roots_r;
  node_t  cur_v_r;
  count_t scan_j_r;
  logic   out_valid_r;
  key_t   res_r;

  logic   acc;
  key_t   wkey;
  node_t  scan_j;
  logic   scan_end;
  logic   cand;
  logic   walk_pop;
  logic   edge_ok;
  key_t   mid_calc;

  // matrix memory
  logic                m_we;
  logic [AddrBits-1:0] m_waddr, m_raddr;
  key_t                m_rdata;
  // finish order memory
  logic                f_we;
  node_t               f_waddr, f_raddr, f_wdata, f_rdata;
  // walk stack memory: node and next index
  logic                s_we;
  node_t               s_waddr, s_raddr;
  logic [StackBits-1:0] s_wdata, s_rdata;

  mtsc_ram #(.Width(WeightBits), .Depth(MaxNodes*MaxNodes)) u_mat (
    .clk, .wr_en(m_we), .wr_addr(m_waddr), .wr_data(wkey),
    .rd_addr(m_raddr), .rd_data(m_rdata));
  mtsc_ram #(.Width(NodeBits), .Depth(MaxNodes)) u_fin (
    .clk, .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
    .rd_addr(f_raddr), .rd_data(f_rdata));
  mtsc_ram #(.Width(StackBits), .Depth(MaxNodes)) u_stk (
    .clk, .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
    .rd_addr(s_raddr), .rd_data(s_rdata));

  always_comb begin
    if (node_count_r == '0) begin
      n_use = count_t'(1);
    end else if (node_count_r > CfgBits'(MaxNodes)) begin
      n_use = count_t'(MaxNodes);
    end else begin
      n_use = count_t'(node_count_r);
    end
    n_max = node_t'(n_use - count_t'(1));
  end

  assign in_stall      = (state_r != ST_LOAD) || out_valid_r;
  assign cfg_ready     = (state_r == ST_LOAD) && !out_valid_r && !loading_r;
  assign out_valid     = out_valid_r;
  assign out_threshold = res_r;

  assign acc      = in_valid && !in_stall;
  assign wkey     = to_key(in_weight);
  assign scan_j   = node_t'(scan_j_r);
  assign scan_end = scan_j_r >= n_use;
  assign cand     = (scan_j != cur_v_r) && !vis_r[scan_j];
  assign walk_pop = scan_end || (sp_r >= count_t'(MaxNodes));
  assign edge_ok  = m_rdata <= mid_r;
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    m_we      = (state_r == ST_LOAD) && acc && !load_done_r;
    m_waddr   = {row_r, col_r};
    m_raddr   = pass_r ? {scan_j, cur_v_r} : {cur_v_r, scan_j};
    f_we      = 1'b0;
    f_waddr   = node_t'(done_r);
    f_wdata   = cur_v_r;
    f_raddr   = node_t'(done_r - idx_r - count_t'(1));
    s_we      = 1'b0;
    s_waddr   = node_t'(sp_r - count_t'(1));
    s_wdata   = {cur_v_r, scan_j_r + count_t'(1)};
    s_raddr   = node_t'(sp_r - count_t'(2));
    unique case (state_r)
      ST_LOAD: begin
        if (acc && in_last_entry) state_nxt = ST_PREP;
      end
      ST_PREP:   state_nxt = ST_SEARCH;
      ST_SEARCH: state_nxt = (lo_r < hi_r) ? ST_ROOT : ST_OUT;
      ST_ROOT: begin
        if (!pass_r) begin
          if (idx_r < n_use && !vis_r[node_t'(idx_r)]) state_nxt = ST_SCAN;
        end else if (idx_r >= done_r) begin
          state_nxt = ST_DECIDE;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = vis_r[f_rdata] ? ST_ROOT : ST_SCAN;
      ST_SCAN: begin
        if (walk_pop) begin
          f_we = !pass_r && (done_r < count_t'(MaxNodes));
          state_nxt = (sp_r == count_t'(1)) ? ST_ROOT : ST_STEP;
        end else if (cand) begin
          state_nxt = ST_EDGE;
        end
      end
      ST_EDGE: begin
        s_we = edge_ok;
        state_nxt = ST_SCAN;
      end
      ST_STEP:   state_nxt = ST_SCAN;
      ST_DECIDE: state_nxt = ST_SEARCH;
      ST_OUT:    state_nxt = ST_LOAD;
      default:   state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CfgBits'(MaxNodes);
      row_r <= '0; col_r <= '0; load_done_r <= 1'b0; loading_r <= 1'b0;
      lo_r <= '1; hi_r <= KeyZero; mid_r <= '0;
      vis_r <= '0; pass_r <= 1'b0;
      done_r <= '0; idx_r <= '0; sp_r <= '0; roots_r <= '0;
      cur_v_r <= '0; scan_j_r <= '0;
      out_valid_r <= 1'b0; res_r <= '0;
    end else begin
      if (state_r == ST_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) node_count_r <= cfg_node_count;
      unique case (state_r)
        ST_LOAD: begin
          if (acc) begin
            loading_r <= 1'b1;
            if (!load_done_r) begin
              if (row_r != col_r) begin
                if (wkey < lo_r) lo_r <= wkey;
                if (wkey > hi_r) hi_r <= wkey;
              end
              if (col_r == n_max) begin
                col_r <= '0;
                if (row_r == n_max) load_done_r <= 1'b1;
                else row_r <= row_r + node_t'(1);
              end else begin
                col_r <= col_r + node_t'(1);
              end
            end
          end
        end
        ST_PREP: begin
          if (n_use <= count_t'(1)) begin
            lo_r <= KeyZero;
            hi_r <= KeyZero;
          end else if (lo_r > hi_r) begin
            lo_r <= hi_r;
          end
        end
        ST_SEARCH: begin
          if (lo_r < hi_r) begin
            mid_r <= mid_calc;
            vis_r <= '0; pass_r <= 1'b0; done_r <= '0; idx_r <= '0; roots_r <= '0;
          end
        end
        ST_ROOT: begin
          if (!pass_r) begin
            if (idx_r >= n_use) begin
              pass_r <= 1'b1; idx_r <= '0; vis_r <= '0;
            end else begin
              idx_r <= idx_r + count_t'(1);
              if (!vis_r[node_t'(idx_r)]) begin
                vis_r[node_t'(idx_r)] <= 1'b1;
                cur_v_r <= node_t'(idx_r); scan_j_r <= '0; sp_r <= count_t'(1);
              end
            end
          end
        end
        ST_FETCH: begin
          idx_r <= idx_r + count_t'(1);
          if (!vis_r[f_rdata]) begin
            vis_r[f_rdata] <= 1'b1;
            cur_v_r <= f_rdata; scan_j_r <= '0; sp_r <= count_t'(1);
            roots_r <= roots_r + count_t'(1);
          end
        end
        ST_SCAN: begin
          if (walk_pop) begin
            if (!pass_r && done_r < count_t'(MaxNodes)) done_r <= done_r + count_t'(1);
            sp_r <= sp_r - count_t'(1);
          end else if (!cand) begin
            scan_j_r <= scan_j_r + count_t'(1);
          end
        end
        ST_EDGE: begin
          if (edge_ok) begin
            vis_r[scan_j] <= 1'b1;
            cur_v_r <= scan_j; scan_j_r <= '0;
            sp_r <= sp_r + count_t'(1);
          end else begin
            scan_j_r <= scan_j_r + count_t'(1);
          end
        end
        ST_STEP: begin
          cur_v_r  <= s_rdata[StackBits-1:CountBits];
          scan_j_r <= s_rdata[CountBits-1:0];
        end
        ST_DECIDE: begin
          if (roots_r == count_t'(1)) hi_r <= mid_r;
          else lo_r <= mid_r + key_t'(1);
        end
        ST_OUT: begin
          res_r <= hi_r ^ KeyZero;
          row_r <= '0; col_r <= '0; load_done_r <= 1'b0; loading_r <= 1'b0;
          lo_r <= '1; hi_r <= KeyZero;
          vis_r <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> !out_valid_r) else $error("result overwritten before taken");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_threshold))
    else $error("result dropped");
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= count_t'(MaxNodes)) else $error("stack overflow");
`endif
endmodule

/* sim/tb_top.sv */
// Testbench for min_threshold_strong_connectivity: loads weight matrices and checks
// each threshold against a built-in Kosaraju/binary-search predictor.
// Depends on mtsc_pkg and the block's RTL only.
module tb_top;
  import mtsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] weight;
    bit          last;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_weight = '0;
  logic in_last_entry = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_threshold;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgBits-1:0] cfg_node_count = '0;

  min_threshold_strong_connectivity dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_weight, .in_last_entry,
    .out_valid, .out_stall, .out_threshold, .cfg_valid, .cfg_ready, .cfg_node_count
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  entry_t pending_entries[$];
  logic [31:0] expected_thresholds[$];
  int errors = 0;
  int thresholds_checked = 0;
  int entries_sent = 0;
  int matrices = 0;
  bit calm = 0;
  int hold_requests = 0;

  // predictor state
  logic [CfgBits-1:0] node_cfg = 7'd64;
  logic [31:0] wmat [0:MaxNodes*MaxNodes-1];
  bit seen [0:MaxNodes-1];
  int fin [0:MaxNodes-1];
  int stk_node [0:MaxNodes-1];
  int stk_next [0:MaxNodes-1];
  int fin_cnt;
  int load_idx = 0;
  logic [31:0] low_key = 32'hFFFF_FFFF;
  logic [31:0] high_key = 32'h8000_0000;

  function automatic void walk(int s, int n, logic [31:0] t, bit rev, bit rec);
    int sp;
    int v;
    int j;
    logic [31:0] k;
    sp = 1;
    seen[s] = 1;
    stk_node[0] = s;
    stk_next[0] = 0;
    while (sp > 0) begin
      v = stk_node[sp-1];
      j = stk_next[sp-1];
      while (j < n) begin
        k = rev ? wmat[j*MaxNodes+v] : wmat[v*MaxNodes+j];
        if (j != v && !seen[j] && k <= t) break;
        j++;
      end
      if (j < n && sp < MaxNodes) begin
        stk_next[sp-1] = j + 1;
        seen[j] = 1;
        stk_node[sp] = j;
        stk_next[sp] = 0;
        sp++;
      end else begin
        if (rec && fin_cnt < MaxNodes) begin
          fin[fin_cnt] = v;
          fin_cnt++;
        end
        sp--;
      end
    end
  endfunction

  function automatic bit strongly_connected(int n, logic [31:0] t);
    int roots;
    int done;
    int v;
    fin_cnt = 0;
    foreach (seen[i]) seen[i] = 0;
    for (int i = 0; i < n; i++) if (!seen[i]) walk(i, n, t, 0, 1);
    foreach (seen[i]) seen[i] = 0;
    roots = 0;
    done = fin_cnt;
    for (int i = 0; i < done; i++) begin
      v = fin[done-1-i];
      if (!seen[v]) begin
        roots++;
        walk(v, n, t, 1, 0);
      end
    end
    return roots == 1;
  endfunction

  function automatic void absorb_entry(logic [31:0] w, bit last);
    int n;
    int row;
    int col;
    logic [31:0] key;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] m;
    n = (node_cfg == 0) ? 1 : (node_cfg > MaxNodes) ? MaxNodes : int'(node_cfg);
    key = w ^ 32'h8000_0000;
    if (load_idx < n * n) begin
      row = load_idx / n;
      col = load_idx % n;
      wmat[row*MaxNodes+col] = key;
      if (row != col) begin
        if (key < low_key) low_key = key;
        if (key > high_key) high_key = key;
      end
      load_idx++;
    end
    if (!last) return;
    if (n <= 1) begin
      expected_thresholds = {expected_thresholds, 32'h0};
    end else begin
      lo = low_key;
      hi = high_key;
      if (lo > hi) lo = hi;
      while (lo < hi) begin
        m = lo + (hi - lo) / 2;
        if (strongly_connected(n, m)) hi = m;
        else lo = m + 1;
      end
      expected_thresholds = {expected_thresholds, hi ^ 32'h8000_0000};
    end
    load_idx = 0;
    low_key = 32'hFFFF_FFFF;
    high_key = 32'h8000_0000;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    errors++;
  endtask

  // driver
  int send_gap = 0;
  bit taken = 0;
  always @(posedge clk) begin
    taken <= in_valid && !in_stall;
    if (in_valid && !in_stall) begin
      absorb_entry(in_weight, in_last_entry);
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 14);
        in_valid <= 0;
      end else if (pending_entries.size() > 0) begin
        in_weight <= pending_entries[0].weight;
        in_last_entry <= pending_entries[0].last;
        void'(pending_entries.pop_front());
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall
  int stall_run = 0;
  int hold_cycles = 0;
  int holds_started = 0;
  always @(negedge clk) begin
    if (holds_started != hold_requests) begin
      holds_started <= hold_requests;
      hold_cycles <= 600;
      out_stall <= 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_run <= $urandom_range(0, 14);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_thresholds.size() == 0) begin
        report_mismatch("unexpected threshold", out_threshold, '0);
      end else begin
        if (out_threshold !== expected_thresholds[0])
          report_mismatch("threshold", out_threshold, expected_thresholds[0]);
        void'(expected_thresholds.pop_front());
        thresholds_checked++;
      end
    end
  end

  task automatic push_entry(logic [31:0] w, bit last);
    entry_t e;
    e.weight = w;
    e.last = last;
    pending_entries = {pending_entries, e};
    entries_sent++;
  endtask

  task automatic wait_idle();
    while (!(pending_entries.size() == 0 && !in_valid && expected_thresholds.size() == 0))
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_node_count(logic [CfgBits-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1;
    cfg_node_count <= v;
    do @(posedge clk); while (!cfg_ready);
    node_cfg = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // mode 0 full range, 1 small range, 2 extremes mixed in
  task automatic push_matrix(int n, int mode, int extra);
    logic [31:0] w;
    int total;
    total = n * n + extra;
    for (int i = 0; i < total; i++) begin
      case (mode)
        0: w = $urandom;
        1: w = $urandom_range(0, 7) - 3;
        default: w = ($urandom_range(0, 3) == 0) ? 32'h8000_0000 :
                     ($urandom_range(0, 2) == 0) ? 32'h7FFF_FFFF : $urandom_range(0, 50);
      endcase
      push_entry(w, i == total - 1);
    end
    matrices++;
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    write_node_count(7'd1);
    push_entry(32'd5, 1);
    write_node_count(7'd0);
    push_entry(32'hFFFF_FFFF, 1);
    write_node_count(7'd2);
    push_entry(32'd0, 0);
    push_entry(32'h8000_0000, 0);
    push_entry(32'h7FFF_FFFF, 0);
    push_entry(32'd0, 1);
    push_entry(32'd9, 0);
    push_entry(-32'sd7, 0);
    push_entry(-32'sd3, 0);
    push_entry(32'd9, 0);
    push_entry(32'd100, 0);
    push_entry(32'd200, 1);
    push_entry(32'd4, 1);
    write_node_count(7'd3);
    push_matrix(3, 2, 0);
    push_entry(32'd1, 0);
    push_entry(32'd2, 0);
    push_entry(32'h7FFF_FFFF, 1);
    push_entry(32'd6, 0);
    push_entry(-32'sd6, 1);
    write_node_count(7'd24);
    push_matrix(24, 1, 0);
    write_node_count(7'd16);
    push_matrix(16, 0, 0);
    write_node_count(7'd127);
    push_entry(32'd3, 1);
    write_node_count(7'd5);

    while (entries_sent < 1900) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(0, 9);
        write_node_count(n[CfgBits-1:0]);
      end
      n = (node_cfg == 0) ? 1 : int'(node_cfg);
      if (matrices == 10) begin
        wait_idle();
        hold_requests++;
        repeat (4) push_matrix(n, 1, 0);
      end
      if (matrices == 20) wait_idle();
      if (entries_sent > 1600) calm = 1;
      push_matrix(n, $urandom_range(0, 2),
                  ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Covered %0d matrices of 1 to 24 nodes, %0d entries, %0d thresholds checked.",
             matrices, entries_sent, thresholds_checked);
    $display("Included node count clamping, surplus and early last entries, long stalls.");
    if (errors == 0 && expected_thresholds.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timed out with %0d thresholds outstanding", expected_thresholds.size());
    $display("Regression FAIL");
    $finish;
  end
endmodule
